// ===== rtl/pedestal_mean_sigma_accumulator_assert.svh =====
// Assertion macros for the pedestal mean and sigma accumulator.
// Taken in by the top level; needs nothing else.
`ifndef PEDESTAL_MEAN_SIGMA_ACCUMULATOR_ASSERT_SVH
`define PEDESTAL_MEAN_SIGMA_ACCUMULATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PMSA_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PMSA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pmsa_pkg.sv =====
// Shared constants, codes and the command type of the pedestal accumulator.
// Used by every other file of the block but the assertion header; depends on nothing.
`timescale 1ns / 1ps

package pmsa_pkg;

  localparam int NUM_SLOTS  = 1024;
  localparam int CHANNELS   = 64;
  localparam int ADC_MAX    = 4095;
  localparam int COUNT_BITS = 24;

  localparam int SLOT_W = 10;
  localparam int CH_W   = 6;
  localparam int CARD_W = 11;
  localparam int CHG_W  = 12;
  localparam int ADDR_W = SLOT_W + CH_W;
  localparam int SUM_W  = 36;
  localparam int SQ_W   = 48;
  localparam int HIT_W  = 30;
  localparam int Q_W    = 20;
  localparam int OCC_W  = 8;
  localparam int M_W    = SUM_W + 4;
  localparam int DIV_W  = SQ_W + 8;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = RAD_W / 2;

  localparam logic [1:0] OP_CONFIGURE = 2'd0;
  localparam logic [1:0] OP_SAMPLE    = 2'd1;
  localparam logic [1:0] OP_FINALIZE  = 2'd2;

  localparam logic [Q_W-1:0]   Q_MAX   = {Q_W{1'b1}};
  localparam logic [Q_W-1:0]   MARKER  = Q_W'(ADC_MAX * 16);
  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};
  localparam logic [CH_W-1:0]  LAST_CH = CH_W'(CHANNELS - 1);

  typedef struct packed {
    logic [1:0]            op;
    logic [SLOT_W-1:0]     slot;
    logic [CARD_W-1:0]     card;
    logic [CH_W-1:0]       channel;
    logic [CHG_W-1:0]      charge;
    logic [COUNT_BITS-1:0] n;
    logic                  npos;
  } cmd_t;

endpackage

// ===== rtl/pmsa_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
// Field widths come from pmsa_pkg.
`timescale 1ns / 1ps

interface pmsa_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      opcode;
  logic [pmsa_pkg::SLOT_W-1:0]     slot;
  logic [pmsa_pkg::CARD_W-1:0]     card_id;
  logic [pmsa_pkg::CH_W-1:0]       channel;
  logic [pmsa_pkg::CHG_W-1:0]      charge;
  logic [pmsa_pkg::COUNT_BITS-1:0] event_count;
  logic [pmsa_pkg::COUNT_BITS-1:0] lost_events;

  modport source (output valid, opcode, slot, card_id, channel, charge, event_count,
                  lost_events, input ready);
  modport sink (input valid, opcode, slot, card_id, channel, charge, event_count,
                lost_events, output ready);
endinterface

interface pmsa_out_if;
  logic                       valid;
  logic                       ready;
  logic [pmsa_pkg::CH_W-1:0]  out_channel;
  logic [pmsa_pkg::Q_W-1:0]   mean;
  logic [pmsa_pkg::Q_W-1:0]   sigma;
  logic                       connected;
  logic                       outside_config;
  logic [pmsa_pkg::OCC_W-1:0] occupancy;
  logic                       last;

  modport source (output valid, out_channel, mean, sigma, connected, outside_config,
                  occupancy, last, input ready);
  modport sink (input valid, out_channel, mean, sigma, connected, outside_config,
                occupancy, last, output ready);
endinterface

// ===== rtl/pedestal_mean_sigma_accumulator.sv =====
// Pedestal mean and sigma accumulator: top level with the check register.
// Depends on pmsa_pkg, the channel interfaces, pmsa_front, pmsa_back and
// pedestal_mean_sigma_accumulator_assert.svh.
//
// Items enter on samples (valid/ready) and results leave on results (valid/ready).
// A configure item marks a slot, a sample item adds a charge to one channel of a
// slot, and a finalize item produces 64 result items, channel 0 first, the one for
// channel 63 carrying last. config_we/config_data write the check flag.
// Configure and sample items each take a read and a write of the stores.
// Finalize first runs the occupancy division when the event count is positive, then
// per channel reads the stores; for a positive count, a non-empty channel takes two
// divisions in the shared divider and, unless the mean is too wide, a square root.
// A two-entry command queue lets the intake run ahead of the back end.
// After reset a clearing sweep zeroes all 65536 channel entries and the slot
// flags, one entry a cycle; samples.ready stays low until it ends.
// When the receiver stalls, the output register holds the result and the back end
// waits; the queue fills and then samples.ready drops.
`timescale 1ns / 1ps
`include "pedestal_mean_sigma_accumulator_assert.svh"

module pedestal_mean_sigma_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        config_we,
  input  logic        config_data,
  pmsa_in_if.sink     samples,
  pmsa_out_if.source  results
);

  logic           config_check;
  logic           clearing;
  pmsa_pkg::cmd_t head;
  logic           head_valid;
  logic           pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      config_check <= 1'b1;
    end else if (config_we) begin
      config_check <= config_data;
    end
  end

  pmsa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .clearing   (clearing),
    .samples    (samples),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  pmsa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .config_check (config_check),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .clearing     (clearing),
    .results      (results)
  );

  `PMSA_ASSERT_NOW(a_no_intake_while_clearing, clk, rst, clearing, !samples.ready, "item taken during clearing")
  `PMSA_ASSERT_NOW(a_no_result_while_clearing, clk, rst, clearing, !results.valid, "result during clearing")
  `PMSA_ASSERT_NOW(a_last_marks_top_channel, clk, rst, results.valid, results.last == (results.out_channel == pmsa_pkg::LAST_CH), "last flag on wrong channel")

endmodule

// ===== rtl/pmsa_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by the finalize path.
// Depends on pmsa_pkg for its widths.
`timescale 1ns / 1ps

module pmsa_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pmsa_pkg::DIV_W-1:0]      dividend,
  input  logic [pmsa_pkg::COUNT_BITS-1:0] divisor,
  output logic                            done,
  output logic [pmsa_pkg::DIV_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(pmsa_pkg::DIV_W);

  logic                            busy;
  logic [CNT_W-1:0]                cnt;
  logic [pmsa_pkg::DIV_W-1:0]      work;
  logic [pmsa_pkg::COUNT_BITS-1:0] rem;
  logic [pmsa_pkg::COUNT_BITS-1:0] dvs;
  logic [pmsa_pkg::COUNT_BITS:0]   trial;
  logic                            ge;
  logic [pmsa_pkg::COUNT_BITS-1:0] rem_next;

  assign trial    = {rem, work[pmsa_pkg::DIV_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign rem_next = ge ? pmsa_pkg::COUNT_BITS'(trial - {1'b0, dvs})
                       : pmsa_pkg::COUNT_BITS'(trial);
  assign quotient = work;

  // The dividend shifts out at the top while quotient bits shift in below.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        work <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        work <= {work[pmsa_pkg::DIV_W-2:0], ge};
        rem  <= rem_next;
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(pmsa_pkg::DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/pmsa_sqrt.sv =====
// Integer square root, two radicand bits per cycle, for the sigma of a channel.
// Depends on pmsa_pkg for its widths.
`timescale 1ns / 1ps

module pmsa_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [pmsa_pkg::RAD_W-1:0]  radicand,
  output logic                        done,
  output logic [pmsa_pkg::ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(pmsa_pkg::ROOT_W);
  localparam int REM_W = pmsa_pkg::ROOT_W + 4;

  logic                       busy;
  logic [CNT_W-1:0]           cnt;
  logic [pmsa_pkg::RAD_W-1:0] rad;
  logic [REM_W-1:0]           rem;
  logic [REM_W-1:0]           acc;
  logic [REM_W-1:0]           trial;
  logic                       ge;

  // The remainder never exceeds twice the partial root, so two spare bits suffice.
  assign acc   = {rem[REM_W-3:0], rad[pmsa_pkg::RAD_W-1 -: 2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = acc >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rad  <= {rad[pmsa_pkg::RAD_W-3:0], 2'b00};
        rem  <= ge ? acc - trial : acc;
        root <= {root[pmsa_pkg::ROOT_W-2:0], ge};
        cnt  <= cnt + 1'b1;
        if (cnt == CNT_W'(pmsa_pkg::ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/pmsa_front.sv =====
// Intake side: accepts items, drops the unused opcode, forms the event count
// and queues commands for the back end. Depends on pmsa_pkg and pmsa_in_if.
`timescale 1ns / 1ps

module pmsa_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           clearing,
  pmsa_in_if.sink        samples,
  output pmsa_pkg::cmd_t head,
  output logic           head_valid,
  input  logic           pop
);

  pmsa_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           accept;
  logic           push;
  pmsa_pkg::cmd_t incoming;

  assign samples.ready = !clearing && (count != 2'd2);
  assign accept        = samples.valid && samples.ready;
  assign push          = accept && (samples.opcode inside {pmsa_pkg::OP_CONFIGURE,
                                    pmsa_pkg::OP_SAMPLE, pmsa_pkg::OP_FINALIZE});
  assign head          = q[rd_ptr];
  assign head_valid    = count != 2'd0;

  always_comb begin
    incoming.op      = samples.opcode;
    incoming.slot    = samples.slot;
    incoming.card    = samples.card_id;
    incoming.channel = samples.channel;
    incoming.charge  = samples.charge;
    incoming.npos    = samples.event_count > samples.lost_events;
    incoming.n       = incoming.npos ? samples.event_count - samples.lost_events : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        q[wr_ptr] <= incoming;
        wr_ptr    <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/pmsa_back.sv =====
// Execution side: channel and slot stores, read-modify-write of samples and the
// finalize sequence. Depends on pmsa_pkg, pmsa_out_if, pmsa_div and pmsa_sqrt.
`timescale 1ns / 1ps

module pmsa_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           config_check,
  input  pmsa_pkg::cmd_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           clearing,
  pmsa_out_if.source     results
);

  localparam logic [3:0] ST_CLEAR      = 4'd0;
  localparam logic [3:0] ST_IDLE       = 4'd1;
  localparam logic [3:0] ST_UPDATE     = 4'd2;
  localparam logic [3:0] ST_OCC        = 4'd3;
  localparam logic [3:0] ST_OCC_WAIT   = 4'd4;
  localparam logic [3:0] ST_READ       = 4'd5;
  localparam logic [3:0] ST_CHECK      = 4'd6;
  localparam logic [3:0] ST_DIV_M      = 4'd7;
  localparam logic [3:0] ST_DIV_Q      = 4'd8;
  localparam logic [3:0] ST_MUL        = 4'd9;
  localparam logic [3:0] ST_ROOT_START = 4'd10;
  localparam logic [3:0] ST_ROOT       = 4'd11;
  localparam logic [3:0] ST_EMIT       = 4'd12;

  localparam int DEPTH = pmsa_pkg::NUM_SLOTS * pmsa_pkg::CHANNELS;

  logic [pmsa_pkg::SUM_W-1:0] sum_mem [DEPTH];
  logic [pmsa_pkg::SQ_W-1:0]  sq_mem  [DEPTH];
  logic [pmsa_pkg::HIT_W-1:0] hit_mem [pmsa_pkg::NUM_SLOTS];
  logic                       cfg_mem [pmsa_pkg::NUM_SLOTS];
  logic                       oc_mem  [pmsa_pkg::NUM_SLOTS];

  logic [3:0]                     state;
  logic [pmsa_pkg::ADDR_W-1:0]    clr_addr;
  pmsa_pkg::cmd_t                 cmd;
  logic [pmsa_pkg::CH_W-1:0]      ch;
  logic [pmsa_pkg::OCC_W-1:0]     occ;
  logic [pmsa_pkg::SUM_W-1:0]     sum_rd;
  logic [pmsa_pkg::SQ_W-1:0]      sq_rd;
  logic [pmsa_pkg::HIT_W-1:0]     hits_rd;
  logic                           cfg_rd;
  logic                           oc_rd;
  logic [pmsa_pkg::M_W-1:0]       m;
  logic [pmsa_pkg::DIV_W-1:0]     q;
  logic [pmsa_pkg::RAD_W-1:0]     m2;
  logic                           big;

  logic                           slot_rd_en;
  logic                           sum_rd_en;
  logic [pmsa_pkg::SLOT_W-1:0]    slot_raddr;
  logic [pmsa_pkg::ADDR_W-1:0]    sum_raddr;
  logic                           slot_we;
  logic [pmsa_pkg::SLOT_W-1:0]    slot_waddr;
  logic [pmsa_pkg::HIT_W-1:0]     hit_wdata;
  logic                           cfg_wdata;
  logic                           oc_wdata;
  logic                           sum_we;
  logic [pmsa_pkg::ADDR_W-1:0]    sum_waddr;
  logic [pmsa_pkg::SUM_W-1:0]     sum_wdata;
  logic [pmsa_pkg::SQ_W-1:0]      sq_wdata;

  logic                           div_start;
  logic [pmsa_pkg::DIV_W-1:0]     div_dividend;
  logic                           div_done;
  logic [pmsa_pkg::DIV_W-1:0]     div_quot;
  logic                           sq_start;
  logic [pmsa_pkg::RAD_W-1:0]     radicand;
  logic                           sq_done;
  logic [pmsa_pkg::ROOT_W-1:0]    root;

  logic                           cmd_slot_ok;
  logic [pmsa_pkg::HIT_W-1:0]     hits_eff;
  logic                           oflag;
  logic                           conn;
  logic [pmsa_pkg::SUM_W:0]       sum_add;
  logic [pmsa_pkg::SQ_W:0]        sq_add;
  logic [2*pmsa_pkg::CHG_W-1:0]   chg_sq;
  logic [pmsa_pkg::RAD_W-1:0]     q_ext;
  logic [23:0]                    occ_mean;
  logic [pmsa_pkg::Q_W-1:0]       mean_val;
  logic [pmsa_pkg::Q_W-1:0]       sigma_val;
  logic                           out_load;

  pmsa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cmd.n),
    .done     (div_done),
    .quotient (div_quot)
  );

  pmsa_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (root)
  );

  assign clearing    = state == ST_CLEAR;
  assign cmd_slot_ok = 32'(cmd.slot) < pmsa_pkg::NUM_SLOTS;
  assign hits_eff    = cmd_slot_ok ? hits_rd : '0;
  assign oflag       = cmd_slot_ok && oc_rd;
  assign conn        = cmd_slot_ok && (sum_rd != '0);
  assign chg_sq      = cmd.charge * cmd.charge;
  assign sum_add     = {1'b0, sum_rd} + (pmsa_pkg::SUM_W + 1)'(cmd.charge);
  assign sq_add      = {1'b0, sq_rd} + (pmsa_pkg::SQ_W + 1)'(chg_sq);
  assign q_ext       = pmsa_pkg::RAD_W'(q);
  assign radicand    = (q_ext >= m2) ? q_ext - m2 : m2 - q_ext;

  // Front-end handshake, memory reads, unit starts and the output register load.
  always_comb begin
    pop          = 1'b0;
    slot_rd_en   = 1'b0;
    sum_rd_en    = 1'b0;
    slot_raddr   = head.slot;
    sum_raddr    = {head.slot, head.channel};
    div_start    = 1'b0;
    div_dividend = pmsa_pkg::DIV_W'(hits_eff[pmsa_pkg::HIT_W-1:6]);
    sq_start     = 1'b0;
    out_load     = 1'b0;
    case (state)
      ST_IDLE: begin
        pop        = head_valid;
        slot_rd_en = head_valid;
        sum_rd_en  = head_valid;
      end
      ST_OCC: begin
        div_start = cmd.npos;
      end
      ST_READ: begin
        sum_rd_en = 1'b1;
        sum_raddr = {cmd.slot, ch};
      end
      ST_CHECK: begin
        div_start    = conn && cmd.npos;
        div_dividend = pmsa_pkg::DIV_W'({sum_rd, 4'b0000});
      end
      ST_DIV_M: begin
        div_start    = div_done;
        div_dividend = {sq_rd, 8'h00};
      end
      ST_ROOT_START: begin
        sq_start = !big;
      end
      ST_EMIT: begin
        out_load = !results.valid || results.ready;
      end
      default: begin
      end
    endcase
  end

  // Store writes: the clearing sweep after reset, then sample and configure updates.
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = cmd.slot;
    hit_wdata  = hits_rd;
    cfg_wdata  = cfg_rd;
    oc_wdata   = oc_rd;
    sum_we     = 1'b0;
    sum_waddr  = {cmd.slot, cmd.channel};
    sum_wdata  = sum_add[pmsa_pkg::SUM_W] ? {pmsa_pkg::SUM_W{1'b1}}
                                          : sum_add[pmsa_pkg::SUM_W-1:0];
    sq_wdata   = sq_add[pmsa_pkg::SQ_W] ? {pmsa_pkg::SQ_W{1'b1}}
                                        : sq_add[pmsa_pkg::SQ_W-1:0];
    if (state == ST_CLEAR) begin
      slot_we    = 1'b1;
      slot_waddr = clr_addr[pmsa_pkg::SLOT_W-1:0];
      hit_wdata  = '0;
      cfg_wdata  = 1'b0;
      oc_wdata   = 1'b0;
      sum_we     = 1'b1;
      sum_waddr  = clr_addr;
      sum_wdata  = '0;
      sq_wdata   = '0;
    end else if (state == ST_UPDATE && cmd_slot_ok) begin
      slot_we = 1'b1;
      if (cmd.op == pmsa_pkg::OP_CONFIGURE) begin
        cfg_wdata = 1'b1;
        if (hits_rd == '0) begin
          hit_wdata = pmsa_pkg::HIT_W'(1);
        end
      end else begin
        sum_we = 1'b1;
        if (hits_rd == '0) begin
          hit_wdata = pmsa_pkg::HIT_W'(1);
          oc_wdata  = oc_rd || config_check;
        end else if (hits_rd != pmsa_pkg::HIT_MAX) begin
          hit_wdata = hits_rd + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (slot_we) begin
      hit_mem[slot_waddr] <= hit_wdata;
      cfg_mem[slot_waddr] <= cfg_wdata;
      oc_mem[slot_waddr]  <= oc_wdata;
    end
    if (slot_rd_en) begin
      hits_rd <= hit_mem[slot_raddr];
      cfg_rd  <= cfg_mem[slot_raddr];
      oc_rd   <= oc_mem[slot_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[sum_waddr] <= sum_wdata;
      sq_mem[sum_waddr]  <= sq_wdata;
    end
    if (sum_rd_en) begin
      sum_rd <= sum_mem[sum_raddr];
      sq_rd  <= sq_mem[sum_raddr];
    end
  end

  // Result fields of the current channel; markers override the computed values.
  always_comb begin
    occ_mean = (24'(pmsa_pkg::ADC_MAX) + 24'(occ)) << 4;
    if (!conn || !cmd.npos) begin
      mean_val  = pmsa_pkg::MARKER;
      sigma_val = pmsa_pkg::MARKER;
    end else begin
      mean_val = (m > pmsa_pkg::M_W'(pmsa_pkg::Q_MAX)) ? pmsa_pkg::Q_MAX
                                                       : m[pmsa_pkg::Q_W-1:0];
      if (big || root > pmsa_pkg::ROOT_W'(pmsa_pkg::Q_MAX)) begin
        sigma_val = pmsa_pkg::Q_MAX;
      end else begin
        sigma_val = root[pmsa_pkg::Q_W-1:0];
      end
      if (cmd.card == '0) begin
        mean_val  = pmsa_pkg::MARKER;
        sigma_val = pmsa_pkg::MARKER;
      end
      if (occ > pmsa_pkg::OCC_W'(1)) begin
        mean_val  = pmsa_pkg::MARKER;
        sigma_val = pmsa_pkg::MARKER;
        if (ch == '0) begin
          mean_val = (occ_mean > 24'(pmsa_pkg::Q_MAX)) ? pmsa_pkg::Q_MAX
                                                       : occ_mean[pmsa_pkg::Q_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      results.valid <= 1'b0;
    end else begin
      if (out_load) begin
        results.valid <= 1'b1;
      end else if (results.ready) begin
        results.valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == pmsa_pkg::ADDR_W'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (head_valid) begin
            cmd   <= head;
            state <= (head.op == pmsa_pkg::OP_FINALIZE) ? ST_OCC : ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          state <= ST_IDLE;
        end
        ST_OCC: begin
          ch <= '0;
          if (cmd.npos) begin
            state <= ST_OCC_WAIT;
          end else begin
            occ   <= '0;
            state <= ST_READ;
          end
        end
        ST_OCC_WAIT: begin
          if (div_done) begin
            occ   <= (div_quot > pmsa_pkg::DIV_W'(255)) ? {pmsa_pkg::OCC_W{1'b1}}
                                                        : div_quot[pmsa_pkg::OCC_W-1:0];
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          state <= (conn && cmd.npos) ? ST_DIV_M : ST_EMIT;
        end
        ST_DIV_M: begin
          if (div_done) begin
            m     <= div_quot[pmsa_pkg::M_W-1:0];
            state <= ST_DIV_Q;
          end
        end
        ST_DIV_Q: begin
          if (div_done) begin
            q     <= div_quot;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          big   <= m[pmsa_pkg::M_W-1:pmsa_pkg::ROOT_W] != '0;
          m2    <= m[pmsa_pkg::ROOT_W-1:0] * m[pmsa_pkg::ROOT_W-1:0];
          state <= ST_ROOT_START;
        end
        ST_ROOT_START: begin
          state <= big ? ST_EMIT : ST_ROOT;
        end
        ST_ROOT: begin
          if (sq_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            ch    <= ch + 1'b1;
            state <= (ch == pmsa_pkg::LAST_CH) ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.out_channel    <= ch;
      results.mean           <= mean_val;
      results.sigma          <= sigma_val;
      results.connected      <= conn;
      results.outside_config <= oflag;
      results.occupancy      <= occ;
      results.last           <= ch == pmsa_pkg::LAST_CH;
    end
  end

endmodule
